[rtl/core/drs_pkg.sv]
`timescale 1ns / 1ps

package drs_pkg;

	// Default sizes of the sorter.
	localparam int DEF_MAX_KEYS   = 64;
	localparam int DEF_DIGIT_BITS = 8;
	localparam int DEF_KEY_BITS   = 32;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;       // store the accepted key or flag it as dropped
		logic start_sort; // reset the pass number, the bin counter and the store select
		logic clr;        // zero one count bin and step the bin counter down
		logic idx_zero;   // point the key index at the first key
		logic idx_top;    // point the key index at the last loaded key
		logic key_rd;     // read both key stores at the key index
		logic cnt_rc;     // counting: take the digit and read its bin, index up
		logic cnt_wr;     // counting: write the incremented bin
		logic sum_rd;     // suffix sum: read one bin and step the bin counter down
		logic sc_rc;      // scatter: take the digit and read its bin, index down
		logic sc_wr;      // scatter: write the decremented bin and place the key
		logic scat_end;   // a pass is done: swap the stores and advance the pass
		logic emit_rd;    // read one sorted key for the result register
	} drs_cmd_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic bin_zero;   // bin counter sits at the lowest bin
		logic last;       // the element just read was the last of the sweep
		logic pass_last;  // the current pass is the final one
		logic emit_ok;    // a result read may be issued this cycle
		logic emit_last;  // the next result read is the final key
	} drs_status_t;

endpackage

[rtl/core/drs_datapath.sv]
`timescale 1ns / 1ps

module drs_datapath #(
	parameter int MAX_KEYS   = drs_pkg::DEF_MAX_KEYS,
	parameter int DIGIT_BITS = drs_pkg::DEF_DIGIT_BITS,
	parameter int KEY_BITS   = drs_pkg::DEF_KEY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [KEY_BITS-1:0] key_value,
	input  drs_pkg::drs_cmd_t   cmd,
	output drs_pkg::drs_status_t status,
	input  logic                result_ready,
	output logic                result_valid,
	output logic [KEY_BITS-1:0] sorted_key,
	output logic                final_result,
	output logic                keys_dropped
);

	localparam int AW         = $clog2(MAX_KEYS);
	localparam int CW         = $clog2(MAX_KEYS + 1);
	localparam int BIN_COUNT  = 1 << DIGIT_BITS;
	localparam int PASS_COUNT = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PW         = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;
	localparam int SW         = $clog2(KEY_BITS + DIGIT_BITS);

	// Two key stores used in turn as source and destination, and the bin counts.
	logic [KEY_BITS-1:0] key_store     [MAX_KEYS];
	logic [KEY_BITS-1:0] scratch_store [MAX_KEYS];
	logic [CW-1:0]       digit_counts  [BIN_COUNT];

	// Control registers.
	logic [CW-1:0]         kc_q;
	logic                  ovf_q;
	logic [CW-1:0]         idx_q;
	logic [DIGIT_BITS-1:0] bin_q;
	logic [PW-1:0]         pass_q;
	logic                  sel_q;
	logic                  last_q;
	logic [CW-1:0]         acc_q;
	logic                  sum_v_s1;
	logic                  rd_pend_s1;
	logic                  result_valid_q;

	// Payload registers.
	logic [KEY_BITS-1:0]   a_rdata_q;
	logic [KEY_BITS-1:0]   b_rdata_q;
	logic [CW-1:0]         cnt_rdata_q;
	logic [DIGIT_BITS-1:0] dig_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [DIGIT_BITS-1:0] bin_s1;
	logic                  fin_s1;
	logic                  drop_s1;
	logic [KEY_BITS-1:0]   sorted_key_q;
	logic                  final_q;
	logic                  dropped_q;

	logic                           full;
	logic [KEY_BITS-1:0]            key_rd_data;
	logic [SW-1:0]                  shamt;
	logic [KEY_BITS+DIGIT_BITS-1:0] key_ext;
	logic [DIGIT_BITS-1:0]          digit;
	logic [CW-1:0]                  sum_acc;
	logic [CW-1:0]                  pos;
	logic                           cnt_re;
	logic [DIGIT_BITS-1:0]          cnt_raddr;
	logic                           cnt_we;
	logic [DIGIT_BITS-1:0]          cnt_waddr;
	logic [CW-1:0]                  cnt_wdata;
	logic                           a_we;
	logic [AW-1:0]                  a_waddr;
	logic [KEY_BITS-1:0]            a_wdata;
	logic                           b_we;
	logic                           emit_last;

	assign full        = (kc_q == CW'(MAX_KEYS));
	assign key_rd_data = sel_q ? b_rdata_q : a_rdata_q;
	assign shamt       = SW'(pass_q) * SW'(DIGIT_BITS);
	assign key_ext     = {{DIGIT_BITS{1'b0}}, key_rd_data} >> shamt;
	assign digit       = key_ext[DIGIT_BITS-1:0];
	assign sum_acc     = acc_q + cnt_rdata_q;
	assign pos         = cnt_rdata_q - CW'(1);
	assign emit_last   = ((idx_q + CW'(1)) == kc_q);

	assign cnt_re    = cmd.cnt_rc | cmd.sc_rc | cmd.sum_rd;
	assign cnt_raddr = cmd.sum_rd ? bin_q : digit;

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = bin_q;
		cnt_wdata = '0;
		if (cmd.clr) begin
			cnt_we = 1'b1;
		end else if (cmd.cnt_wr) begin
			cnt_we    = 1'b1;
			cnt_waddr = dig_q;
			cnt_wdata = cnt_rdata_q + CW'(1);
		end else if (cmd.sc_wr) begin
			cnt_we    = 1'b1;
			cnt_waddr = dig_q;
			cnt_wdata = pos;
		end else if (sum_v_s1) begin
			cnt_we    = 1'b1;
			cnt_waddr = bin_s1;
			cnt_wdata = sum_acc;
		end
	end

	assign a_we    = (cmd.load && !full) || (cmd.sc_wr && sel_q);
	assign a_waddr = cmd.load ? kc_q[AW-1:0] : pos[AW-1:0];
	assign a_wdata = cmd.load ? key_value : key_q;
	assign b_we    = cmd.sc_wr && !sel_q;

	always_ff @(posedge clk) begin
		if (a_we) begin
			key_store[a_waddr] <= a_wdata;
		end
		if (b_we) begin
			scratch_store[pos[AW-1:0]] <= key_q;
		end
		if (cmd.key_rd) begin
			a_rdata_q <= key_store[idx_q[AW-1:0]];
			b_rdata_q <= scratch_store[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			digit_counts[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rdata_q <= digit_counts[cnt_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q           <= '0;
			ovf_q          <= 1'b0;
			idx_q          <= '0;
			bin_q          <= '1;
			pass_q         <= '0;
			sel_q          <= 1'b0;
			last_q         <= 1'b0;
			acc_q          <= '0;
			sum_v_s1       <= 1'b0;
			rd_pend_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					kc_q <= kc_q + CW'(1);
				end
			end
			if (cmd.start_sort) begin
				pass_q <= '0;
				sel_q  <= 1'b0;
				bin_q  <= '1;
			end
			if (cmd.clr || cmd.sum_rd) begin
				bin_q <= bin_q - DIGIT_BITS'(1);
			end
			if (cmd.clr) begin
				acc_q <= '0;
			end else if (sum_v_s1) begin
				acc_q <= sum_acc;
			end
			if (cmd.idx_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_top) begin
				idx_q <= kc_q - CW'(1);
			end else if (cmd.cnt_rc) begin
				idx_q  <= idx_q + CW'(1);
				last_q <= ((idx_q + CW'(1)) == kc_q);
			end else if (cmd.sc_rc) begin
				idx_q  <= idx_q - CW'(1);
				last_q <= (idx_q == '0);
			end else if (cmd.emit_rd) begin
				idx_q <= idx_q + CW'(1);
				if (emit_last) begin
					kc_q  <= '0;
					ovf_q <= 1'b0;
				end
			end
			if (cmd.scat_end) begin
				sel_q  <= ~sel_q;
				pass_q <= pass_q + PW'(1);
			end
			sum_v_s1   <= cmd.sum_rd;
			rd_pend_s1 <= cmd.emit_rd;
			if (rd_pend_s1) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_s1 <= bin_q;
		if (cmd.cnt_rc || cmd.sc_rc) begin
			dig_q <= digit;
		end
		if (cmd.sc_rc) begin
			key_q <= key_rd_data;
		end
		if (cmd.emit_rd) begin
			fin_s1  <= emit_last;
			drop_s1 <= ovf_q;
		end
		if (rd_pend_s1) begin
			sorted_key_q <= key_rd_data;
			final_q      <= fin_s1;
			dropped_q    <= drop_s1;
		end
	end

	assign status.bin_zero  = (bin_q == '0);
	assign status.last      = last_q;
	assign status.pass_last = (pass_q == PW'(PASS_COUNT - 1));
	assign status.emit_ok   = !rd_pend_s1 && (!result_valid_q || result_ready);
	assign status.emit_last = emit_last;

	assign result_valid = result_valid_q;
	assign sorted_key   = sorted_key_q;
	assign final_result = final_q;
	assign keys_dropped = dropped_q;

	// A key read for the result register only lands in an empty register.
	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !result_valid_q)
		else $error("result register overwritten before transfer");

	// The fill count never passes the store depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		kc_q <= CW'(MAX_KEYS))
		else $error("key count beyond capacity");

	// A dropped key can only have been seen with the store full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flag set with room left");

	// The suffix-sum write owns the count write port alone.
	a_sum_port: assert property (@(posedge clk) disable iff (!arst_n)
		sum_v_s1 |-> !(cmd.clr || cmd.cnt_wr || cmd.sc_wr))
		else $error("count write port conflict");

endmodule

[rtl/core/drs_ctrl.sv]
`timescale 1ns / 1ps

module drs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_valid,
	input  logic                 last_key,
	output logic                 key_ready,
	input  drs_pkg::drs_status_t status,
	output drs_pkg::drs_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLR,
		ST_CNT_RK,
		ST_CNT_RC,
		ST_CNT_WR,
		ST_SUM,
		ST_SUM_LAST,
		ST_SC_RK,
		ST_SC_RC,
		ST_SC_WR,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		key_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				key_ready = 1'b1;
				if (key_valid) begin
					cmd.load = 1'b1;
					if (last_key) begin
						cmd.start_sort = 1'b1;
						state_d        = ST_CLR;
					end
				end
			end
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (status.bin_zero) begin
					cmd.idx_zero = 1'b1;
					state_d      = ST_CNT_RK;
				end
			end
			ST_CNT_RK: begin
				cmd.key_rd = 1'b1;
				state_d    = ST_CNT_RC;
			end
			ST_CNT_RC: begin
				cmd.cnt_rc = 1'b1;
				state_d    = ST_CNT_WR;
			end
			ST_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				if (status.last) begin
					state_d = ST_SUM;
				end else begin
					cmd.key_rd = 1'b1;
					state_d    = ST_CNT_RC;
				end
			end
			ST_SUM: begin
				cmd.sum_rd = 1'b1;
				if (status.bin_zero) begin
					state_d = ST_SUM_LAST;
				end
			end
			ST_SUM_LAST: begin
				cmd.idx_top = 1'b1;
				state_d     = ST_SC_RK;
			end
			ST_SC_RK: begin
				cmd.key_rd = 1'b1;
				state_d    = ST_SC_RC;
			end
			ST_SC_RC: begin
				cmd.sc_rc = 1'b1;
				state_d   = ST_SC_WR;
			end
			ST_SC_WR: begin
				cmd.sc_wr = 1'b1;
				if (status.last) begin
					cmd.scat_end = 1'b1;
					if (status.pass_last) begin
						cmd.idx_zero = 1'b1;
						state_d      = ST_EMIT;
					end else begin
						state_d = ST_CLR;
					end
				end else begin
					cmd.key_rd = 1'b1;
					state_d    = ST_SC_RC;
				end
			end
			ST_EMIT: begin
				if (status.emit_ok) begin
					cmd.emit_rd = 1'b1;
					cmd.key_rd  = 1'b1;
					if (status.emit_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// A result read is only issued while the result path can take it.
	a_emit_gate: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rd |-> (status.emit_ok && state_q == ST_EMIT))
		else $error("result read without room");

endmodule

[rtl/core/descending_radix_sorter.sv]
// A set of n keys loads at one key per cycle while the sequencer sits in its
// load state; no key is taken while a set is sorted or its results go out.
// Sorting runs P passes of D-bit digits; its speed is set by the count memory's
// single read and write port and the clear and suffix-sum sweeps. Results then
// follow one at a time, each read only once the result register can take it.
// Reset (arst_n, asynchronous, active low) empties the set; stores need no clearing.
`timescale 1ns / 1ps

module descending_radix_sorter #(
	parameter int MAX_KEYS   = drs_pkg::DEF_MAX_KEYS,
	parameter int DIGIT_BITS = drs_pkg::DEF_DIGIT_BITS,
	parameter int KEY_BITS   = drs_pkg::DEF_KEY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// Key channel.
	input  logic                key_valid,
	output logic                key_ready,
	input  logic [KEY_BITS-1:0] key_value,
	input  logic                last_key,
	// Result channel.
	output logic                result_valid,
	input  logic                result_ready,
	output logic [KEY_BITS-1:0] sorted_key,
	output logic                final_result,
	output logic                keys_dropped
);

	// The sorter is a sequencer and a datapath. Keys are written into the key
	// store while the sequencer waits in its load state; a key that arrives with
	// the store full is discarded and remembered, so that every result of the set
	// reports the drop. A transfer marked last starts the sort.
	//
	// Each pass of the least-significant-digit sort runs four sweeps:
	//   - the count memory is cleared, one bin per cycle, from the top bin down;
	//   - every key is read and its digit bin is incremented (a read state and a
	//     write-back state per key, since the bin read and its write-back share one memory port pair);
	//   - the bins are turned into suffix sums from the top bin down, which puts
	//     larger digits at lower positions and so yields descending order;
	//   - the keys are walked from the last to the first, each bin is
	//     decremented and the key is written to that position of the other store.
	// The two key stores swap roles after every pass instead of copying back.
	//
	// Results come from a register that holds one sorted key until its transfer,
	// so the final result can wait on the output while the next set loads.

	drs_pkg::drs_cmd_t    cmd;
	drs_pkg::drs_status_t status;

	drs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.last_key  (last_key),
		.key_ready (key_ready),
		.status    (status),
		.cmd       (cmd)
	);

	drs_datapath #(
		.MAX_KEYS   (MAX_KEYS),
		.DIGIT_BITS (DIGIT_BITS),
		.KEY_BITS   (KEY_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_value    (key_value),
		.cmd          (cmd),
		.status       (status),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.sorted_key   (sorted_key),
		.final_result (final_result),
		.keys_dropped (keys_dropped)
	);

endmodule
